/* hw/rtl/nail_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nail_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int DEFAULT_ANGLE_BITS  = 19;

  // Width of the signed entry index carried by a command item.
  localparam int INDEX_W = 12;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRAP  = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/nail_channels.sv */
`timescale 1ns / 1ps
`default_nettype none

interface nail_req_if
  import nail_pkg::*;
#(
  parameter int ANGLE_BITS = DEFAULT_ANGLE_BITS
) ();
  logic                         valid;
  logic                         ready;
  cmd_t                         command;
  logic signed [INDEX_W-1:0]    index;
  logic signed [ANGLE_BITS-1:0] angle;

  modport source (output valid, output command, output index, output angle, input ready);
  modport sink   (input valid, input command, input index, input angle, output ready);
endinterface

interface nail_res_if
  import nail_pkg::*;
#(
  parameter int ANGLE_BITS = DEFAULT_ANGLE_BITS,
  parameter int FOUND_W    = $clog2(DEFAULT_TABLE_DEPTH)
) ();
  logic                         valid;
  logic                         ready;
  logic [FOUND_W-1:0]           found_index;
  logic signed [ANGLE_BITS-1:0] angle_out;
  logic                         index_error;

  modport source (output valid, output found_index, output angle_out, output index_error,
                  input ready);
  modport sink   (input valid, input found_index, input angle_out, input index_error,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/nail_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module nail_engine
  import nail_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int ANGLE_BITS  = DEFAULT_ANGLE_BITS,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic [CW-1:0] count,
  nail_req_if.sink     request,
  nail_res_if.source   result
);

  localparam int DW = ANGLE_BITS + 1;
  localparam int RW = ((INDEX_W > CW) ? INDEX_W : CW) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_FIRST, S_LAST, S_ORDER, S_PROBE, S_CMP,
    S_RESOLVE, S_NB1, S_NB2, S_FETCH, S_DONE
  } state_t;

  state_t                       state;
  cmd_t                         cmd;
  logic signed [INDEX_W-1:0]    idx;
  logic signed [ANGLE_BITS-1:0] val;
  logic [CW-1:0]                first;
  logic [CW-1:0]                len;
  logic                         asc;
  logic signed [ANGLE_BITS-1:0] a0;
  logic signed [ANGLE_BITS-1:0] hi_data;
  logic [DW-1:0]                dn;
  logic [AW-1:0]                found;
  logic [AW-1:0]                res_found;
  logic signed [ANGLE_BITS-1:0] res_angle;
  logic                         res_err;

  logic signed [ANGLE_BITS-1:0] mem [TABLE_DEPTH];
  logic signed [ANGLE_BITS-1:0] rd_data;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;

  logic [CW-1:0]    half;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    probe_pos;
  logic [CW-1:0]    found_c;
  logic signed [RW-1:0] idx_s;
  logic signed [RW-1:0] cnt_s;
  logic signed [RW-1:0] r_s;
  logic             r_ok;
  logic signed [DW-1:0] diff_hi;
  logic signed [DW-1:0] diff_lo;
  logic [DW-1:0]    abs_hi;
  logic [DW-1:0]    abs_lo;

  assign request.ready = (state == S_IDLE);

  assign wr_en = (state == S_IDLE) && request.valid && (request.command == CMD_WRITE) &&
                 !request.index[INDEX_W-1] &&
                 ({1'b0, request.index} < (INDEX_W + 1)'(TABLE_DEPTH));

  // Search position; a descending table is walked in reverse order.
  assign half      = len >> 1;
  assign mid       = first + half;
  assign probe_pos = asc ? mid : (count - CW'(1) - mid);
  assign found_c   = asc ? first : (count - first);

  // Resolved read index, wrapped once for the wrapped read command.
  assign idx_s = RW'(idx);
  assign cnt_s = $signed(RW'(count));
  always_comb begin
    r_s = idx_s;
    if (cmd == CMD_WRAP) begin
      if (idx_s < 0) begin
        r_s = idx_s + cnt_s;
      end else if (idx_s >= cnt_s) begin
        r_s = idx_s - cnt_s;
      end
    end
  end
  assign r_ok = (r_s >= 0) && (r_s < cnt_s);

  assign diff_hi = DW'(rd_data) - DW'(val);
  assign diff_lo = DW'(val) - DW'(rd_data);
  assign abs_hi  = (diff_hi < 0) ? DW'(-diff_hi) : DW'(diff_hi);
  assign abs_lo  = (diff_lo < 0) ? DW'(-diff_lo) : DW'(diff_lo);

  always_comb begin
    rd_addr = '0;
    unique case (state)
      S_RANGE:   rd_addr = r_s[AW-1:0];
      S_LAST:    rd_addr = AW'(count - CW'(1));
      S_PROBE:   rd_addr = probe_pos[AW-1:0];
      S_RESOLVE: begin
        if (found_c == '0) begin
          rd_addr = '0;
        end else if (found_c >= count) begin
          rd_addr = AW'(count - CW'(1));
        end else begin
          rd_addr = found_c[AW-1:0];
        end
      end
      S_NB1:     rd_addr = found - AW'(1);
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[request.index[AW-1:0]] <= request.angle;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            cmd <= request.command;
            idx <= request.index;
            val <= request.angle;
            case (request.command) inside
              CMD_WRITE:          state <= S_IDLE;
              CMD_FIND:           state <= S_FIRST;
              CMD_READ, CMD_WRAP: state <= S_RANGE;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_RANGE: begin
          if (r_ok) begin
            res_found <= r_s[AW-1:0];
            res_err   <= 1'b0;
            state     <= S_FETCH;
          end else begin
            res_found <= '0;
            res_angle <= '0;
            res_err   <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_FIRST: begin
          state <= S_LAST;
        end
        S_LAST: begin
          a0    <= rd_data;
          state <= S_ORDER;
        end
        S_ORDER: begin
          asc     <= (a0 < rd_data);
          first   <= '0;
          len     <= count;
          res_err <= 1'b0;
          state   <= S_PROBE;
        end
        S_PROBE: begin
          state <= (len == '0) ? S_RESOLVE : S_CMP;
        end
        S_CMP: begin
          if (val < rd_data) begin
            len <= half;
          end else begin
            first <= mid + CW'(1);
            len   <= len - half - CW'(1);
          end
          state <= S_PROBE;
        end
        S_RESOLVE: begin
          found <= found_c[AW-1:0];
          if (found_c == '0) begin
            res_found <= '0;
            state     <= S_FETCH;
          end else if (found_c >= count) begin
            res_found <= AW'(count - CW'(1));
            state     <= S_FETCH;
          end else begin
            state <= S_NB1;
          end
        end
        S_NB1: begin
          hi_data <= rd_data;
          dn      <= abs_hi;
          state   <= S_NB2;
        end
        S_NB2: begin
          // Equal distances go to the lower neighbor.
          if (dn < abs_lo) begin
            res_found <= found;
            res_angle <= hi_data;
          end else begin
            res_found <= found - AW'(1);
            res_angle <= rd_data;
          end
          state <= S_DONE;
        end
        S_FETCH: begin
          res_angle <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.found_index <= res_found;
            result.angle_out   <= res_angle;
            result.index_error <= res_err;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nearest_angle_index_lookup.sv */
// Nearest beam-angle lookup over one monotonic table of signed angles.
// Commands arrive as items on the request channel (valid/ready): write an
// entry, find the entry nearest to an angle, checked read, or wrapped read.
// Every command but a write returns one item on the result channel with the
// index, the table angle and an error flag. The entry count is written on
// cfg_we/cfg_wdata; the user must do so only while the block is idle, which
// the block does not enforce. 0 acts as 1, larger than the depth acts as the
// depth. One item is worked at a time and request.ready is low until it is
// done. A write in range is stored as it is accepted. A read checks its
// index, then fetches the entry; an index out of range skips the fetch. A
// search reads the first and last entries for the order, then runs
// binary-search steps (one registered read of the table port, one compare
// each) over at most ceil(log2(n+1)) steps, then the final check, the
// neighbor compare and the output (no neighbor compare when clamped to an
// end). The single table read port is why these reads come in turn.
// The result sits in an output register; request.ready rises in the same
// cycle as the result appears, and a finished item waits in place while the
// receiver stalls. Reset clears the control state and sets the entry count
// to 1; table entries are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module nearest_angle_index_lookup
  import nail_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int ANGLE_BITS  = DEFAULT_ANGLE_BITS,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_wdata,
  nail_req_if.sink           request,
  nail_res_if.source         result
);

  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        count <= CW'(1);
      end else if (cfg_wdata > CW'(TABLE_DEPTH)) begin
        count <= CW'(TABLE_DEPTH);
      end else begin
        count <= cfg_wdata;
      end
    end
  end

  nail_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .count   (count),
    .request (request),
    .result  (result)
  );

endmodule

`default_nettype wire

/* dv/nearest_angle_index_lookup_tb.sv */
`timescale 1ns / 1ps

module nearest_angle_index_lookup_tb;
  import nail_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int ANGLE_W = DEFAULT_ANGLE_BITS;
  localparam int FOUND_W = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam longint ANGLE_MIN = -(longint'(1) << (ANGLE_W - 1));
  localparam longint ANGLE_MAX = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam int IDX_MIN = -1024;
  localparam int IDX_MAX = 2047;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum {
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_RISING_RANDOM,
    SHAPE_NOISE
  } table_shape_t;

  typedef struct {
    logic [FOUND_W-1:0]        found_index;
    logic signed [ANGLE_W-1:0] angle_out;
    logic                      index_error;
  } lookup_res_t;

  class lookup_scoreboard;
    logic signed [ANGLE_W-1:0] angles[TABLE_DEPTH];
    logic [COUNT_W-1:0]        count_reg;
    lookup_res_t               results_due[$];
    int mismatches, searches, checked_reads, wrapped_reads, writes, writes_dropped, flagged;

    function new();
      count_reg = COUNT_W'(1);
    endfunction

    function void set_count(logic [COUNT_W-1:0] v);
      count_reg = v;
    endfunction

    function int live_count();
      if (count_reg == 0) return 1;
      if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(count_reg);
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    // A falling table is searched back to front so the same upper bound applies.
    function longint probe(int n, bit rev, int r);
      return angles[rev ? n - 1 - r : r];
    endfunction

    function int search_pos(int n, bit rev, longint val);
      int first, len, half;
      first = 0;
      len = n;
      while (len > 0) begin
        half = len >> 1;
        if (val < probe(n, rev, first + half)) begin
          len = half;
        end else begin
          first = first + half + 1;
          len = len - half - 1;
        end
      end
      return first;
    endfunction

    function int nearest_entry(longint val);
      int n, pos;
      longint above, below;
      n = live_count();
      if (angles[0] < angles[n-1]) pos = search_pos(n, 1'b0, val);
      else pos = n - search_pos(n, 1'b1, val);
      if (pos == 0) return 0;
      if (pos >= n) return n - 1;
      above = longint'(angles[pos]) - val;
      if (above < 0) above = -above;
      below = val - longint'(angles[pos-1]);
      if (below < 0) below = -below;
      // Equal distances go to the lower index.
      return (above < below) ? pos : pos - 1;
    endfunction

    function void note_request(cmd_t c, logic signed [INDEX_W-1:0] idx,
                               logic signed [ANGLE_W-1:0] ang);
      lookup_res_t r;
      int n, pos;
      n = live_count();
      pos = int'(idx);
      r.found_index = '0;
      r.angle_out = '0;
      r.index_error = 1'b0;
      case (c)
        CMD_WRITE: begin
          writes++;
          if (pos >= 0 && pos < TABLE_DEPTH) angles[pos] = ang;
          else writes_dropped++;
          return;
        end
        CMD_FIND: begin
          searches++;
          pos = nearest_entry(longint'(ang));
          r.found_index = FOUND_W'(pos);
          r.angle_out = angles[pos];
        end
        default: begin
          if (c == CMD_WRAP) begin
            wrapped_reads++;
            if (pos < 0) pos = pos + n;
            else if (pos >= n) pos = pos - n;
          end else begin
            checked_reads++;
          end
          if (pos >= 0 && pos < n) begin
            r.found_index = FOUND_W'(pos);
            r.angle_out = angles[pos];
          end else begin
            r.index_error = 1'b1;
            flagged++;
          end
        end
      endcase
      results_due.insert(results_due.size(), r);
    endfunction

    function void check_result(logic [FOUND_W-1:0] fi, logic signed [ANGLE_W-1:0] ao,
                               logic ie);
      lookup_res_t want;
      if (results_due.size() == 0) begin
        $error("unexpected result item: found_index %0d angle_out %0d index_error %0b",
               fi, ao, ie);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (fi !== want.found_index) begin
        $error("found_index: expected %0d, actual %0d", want.found_index, fi);
        mismatches++;
      end
      if (ao !== want.angle_out) begin
        $error("angle_out: expected %0d, actual %0d", want.angle_out, ao);
        mismatches++;
      end
      if (ie !== want.index_error) begin
        $error("index_error: expected %0b, actual %0b", want.index_error, ie);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  bit                 tx_gaps;
  bit                 rx_gaps;
  bit                 hold_results;
  int unsigned        cycles = 0;
  lookup_scoreboard   sb = new();

  nail_req_if #(.ANGLE_BITS(ANGLE_W)) req_ch ();
  nail_res_if #(.ANGLE_BITS(ANGLE_W), .FOUND_W(FOUND_W)) res_ch ();

  nearest_angle_index_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ANGLE_BITS(ANGLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .request(req_ch),
    .result(res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nearest_angle_index_lookup_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.found_index, res_ch.angle_out, res_ch.index_error);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        res_ch.ready <= !(rx_gaps && ($urandom_range(0, 99) < 31));
      end
    end
  end

  task automatic send_item(input cmd_t c, input int ival, input longint val);
    logic signed [INDEX_W-1:0] idx;
    logic signed [ANGLE_W-1:0] ang;
    idx = ival[INDEX_W-1:0];
    ang = val[ANGLE_W-1:0];
    while (tx_gaps && ($urandom_range(0, 99) < 31)) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= c;
    req_ch.index <= idx;
    req_ch.angle <= ang;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(c, idx, ang);
  endtask

  task automatic stop_request();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes give no result, so a drain wait follows before the block counts as idle.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    settle();
    cfg_wdata <= v[COUNT_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v[COUNT_W-1:0]);
  endtask

  task automatic load_table(input table_shape_t shape, input int m);
    int i;
    longint val;
    val = ANGLE_MIN + longint'($urandom_range(0, 1000));
    for (i = 0; i < m; i++) begin
      case (shape)
        SHAPE_RISING: val = ANGLE_MIN + longint'(i) * 512;
        SHAPE_FALLING: val = ANGLE_MIN + longint'(TABLE_DEPTH - 1 - i) * 512;
        SHAPE_RISING_RANDOM: if (i > 0) val = val + longint'($urandom_range(0, 255));
        default: val = ANGLE_MIN + longint'($urandom_range(0, 2 ** ANGLE_W - 1));
      endcase
      send_item(CMD_WRITE, i, val);
    end
    stop_request();
  endtask

  task automatic random_batch(input int goal);
    int done, n, pick, i, ival;
    longint val, lo, hi;
    cmd_t c;
    done = 0;
    while (done < goal) begin
      n = sb.live_count();
      pick = $urandom_range(0, 99);
      i = $urandom_range(0, n - 1);
      ival = i;
      val = sb.angles[i];
      if (pick < 15) begin
        c = CMD_WRITE;
        case ($urandom_range(0, 5))
          0: begin
            ival = $urandom_range(0, TABLE_DEPTH - 1);
            val = ANGLE_MIN + longint'($urandom_range(0, 2 ** ANGLE_W - 1));
          end
          1: ival = $urandom_range(0, 1) ? -1 - int'($urandom_range(0, 1023))
                                         : TABLE_DEPTH + int'($urandom_range(0, 1023));
          default: begin
            // Stay between the neighbors so the table keeps its order.
            if (i > 0 && i < n - 1) begin
              lo = sb.angles[i-1];
              hi = sb.angles[i+1];
              if (lo > hi) begin
                lo = sb.angles[i+1];
                hi = sb.angles[i-1];
              end
              val = lo + longint'($urandom_range(0, int'(hi - lo)));
            end
          end
        endcase
      end else if (pick < 60) begin
        c = CMD_FIND;
        case ($urandom_range(0, 5))
          0: val = ANGLE_MIN + longint'($urandom_range(0, 2 ** ANGLE_W - 1));
          1: ;
          2: val = val + longint'($urandom_range(0, 64)) - 32;
          3: begin
            // Midway between two neighbors, which is a tie on even gaps.
            if (n > 1) begin
              i = $urandom_range(0, n - 2);
              val = (longint'(sb.angles[i]) + longint'(sb.angles[i+1])) >>> 1;
            end
          end
          4: val = $urandom_range(0, 1) ? ANGLE_MIN : ANGLE_MAX;
          default: val = $urandom_range(0, 1)
                       ? longint'(sb.angles[0]) - longint'($urandom_range(1, 2000))
                       : longint'(sb.angles[n-1]) + longint'($urandom_range(1, 2000));
        endcase
      end else begin
        c = (pick < 80) ? CMD_READ : CMD_WRAP;
        val = ANGLE_MIN + longint'($urandom_range(0, 2 ** ANGLE_W - 1));
        case ($urandom_range(0, 5))
          0: ival = i - n;
          1: ival = i + n;
          2: ival = $urandom_range(0, 1) ? -1 : n;
          3: ival = $urandom_range(0, 1) ? 2 * n : -n - 1;
          4: ival = IDX_MIN + int'($urandom_range(0, IDX_MAX - IDX_MIN));
          default: ;
        endcase
      end
      send_item(c, ival, val);
      if (c != CMD_WRITE || (ival >= 0 && ival < TABLE_DEPTH)) done++;
    end
    stop_request();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.command <= CMD_WRITE;
    req_ch.index <= '0;
    req_ch.angle <= '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_results = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The whole table is written first so that no read ever hits an unwritten entry.
    load_table(SHAPE_RISING, TABLE_DEPTH);
    send_item(CMD_FIND, 0, ANGLE_MIN);
    send_item(CMD_FIND, 0, ANGLE_MAX);
    send_item(CMD_READ, 0, 0);
    send_item(CMD_READ, 1, 0);
    send_item(CMD_READ, -1, 0);
    send_item(CMD_WRAP, 1, 0);
    send_item(CMD_WRAP, -1, 0);
    send_item(CMD_WRAP, 2, 0);
    stop_request();

    write_count(TABLE_DEPTH);
    send_item(CMD_FIND, 0, ANGLE_MIN);
    send_item(CMD_FIND, 0, ANGLE_MAX);
    send_item(CMD_FIND, 0, longint'(sb.angles[5]) + 256);
    send_item(CMD_FIND, 0, longint'(sb.angles[5]) + 257);
    send_item(CMD_FIND, 0, longint'(sb.angles[700]));
    send_item(CMD_READ, 1023, 0);
    send_item(CMD_READ, 1024, 0);
    send_item(CMD_READ, IDX_MIN, 0);
    send_item(CMD_WRAP, -1, 0);
    send_item(CMD_WRAP, IDX_MIN, 0);
    send_item(CMD_WRAP, 1024, 0);
    send_item(CMD_WRAP, IDX_MAX, 0);
    send_item(CMD_WRITE, -1, 12345);
    send_item(CMD_WRITE, 1024, 12345);
    send_item(CMD_WRITE, IDX_MAX, -12345);
    send_item(CMD_WRITE, 1023, ANGLE_MAX);
    send_item(CMD_READ, 1023, 0);
    send_item(CMD_FIND, 0, ANGLE_MAX);
    stop_request();

    random_batch(60);

    write_count(0);
    random_batch(25);

    // A count above the depth acts as the depth, and every entry is already written.
    write_count(2 ** COUNT_W - 1);
    hold_results = 1'b1;
    random_batch(60);

    write_count($urandom_range(50, 200));
    load_table(SHAPE_FALLING, sb.live_count());
    random_batch(50);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_count($urandom_range(2, 40));
    load_table(SHAPE_RISING_RANDOM, sb.live_count());
    random_batch(60);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    write_count($urandom_range(41, 150));
    load_table(SHAPE_NOISE, sb.live_count());
    random_batch(50);

    write_count(2);
    load_table(SHAPE_FALLING, 2);
    random_batch(25);

    write_count(TABLE_DEPTH);
    random_batch(40);

    settle();
    $display("Covered %0d searches, %0d checked reads, %0d wrapped reads, %0d table writes",
             sb.searches, sb.checked_reads, sb.wrapped_reads, sb.writes);
    $display("with %0d dropped writes and %0d flagged reads on rising, falling, noisy tables.",
             sb.writes_dropped, sb.flagged);
    if (sb.mismatches == 0) begin
      $display("nearest_angle_index_lookup_tb passed");
    end else begin
      $display("nearest_angle_index_lookup_tb failed");
    end
    $finish;
  end

endmodule
